>>> hdl/yuyv_pkg.sv
// Shared types and constants for the YUYV to scaled RGB24 converter.
package yuyv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 25;
    localparam int SUM_W     = 26;
    localparam int PIX_W     = 8;
    localparam int SCALE_W   = 2 * PIX_W;

    localparam logic signed [PROD_W-1:0] COEF_RV = PROD_W'(89831);
    localparam logic signed [PROD_W-1:0] COEF_GV = PROD_W'(45744);
    localparam logic signed [PROD_W-1:0] COEF_GU = PROD_W'(22127);
    localparam logic signed [PROD_W-1:0] COEF_BU = PROD_W'(113538);

    localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;
    localparam logic [PIX_W-1:0] SCALE_MUL = 8'd220;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_prod rv;
        t_prod gv;
        t_prod gu;
        t_prod bu;
    } t_chroma_terms;

    typedef struct packed {
        t_sum r;
        t_sum g;
        t_sum b;
    } t_pix_sums;

endpackage

>>> hdl/yuyv_chroma_mul.sv
// First stage: chroma offset products, luma and flag carried alongside.
module yuyv_chroma_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [7:0]                 i_luma_first,
    input  logic [7:0]                 i_chroma_blue,
    input  logic [7:0]                 i_luma_second,
    input  logic [7:0]                 i_chroma_red,
    input  logic                       i_frame_end,
    output logic                       o_valid,
    output logic [7:0]                 o_luma_first,
    output logic [7:0]                 o_luma_second,
    output logic                       o_frame_end,
    output yuyv_pkg::t_chroma_terms    o_terms
);
    import yuyv_pkg::*;

    logic signed [7:0]  w_du;
    logic signed [7:0]  w_dv;
    t_prod              w_du_x;
    t_prod              w_dv_x;
    t_chroma_terms      n_terms;
    t_chroma_terms      r_terms;
    logic               r_valid;
    logic [7:0]         r_luma_first;
    logic [7:0]         r_luma_second;
    logic               r_frame_end;

    // chroma minus 128 is the byte with its top bit flipped
    assign w_du   = {~i_chroma_blue[7], i_chroma_blue[6:0]};
    assign w_dv   = {~i_chroma_red[7], i_chroma_red[6:0]};
    assign w_du_x = t_prod'(w_du);
    assign w_dv_x = t_prod'(w_dv);

    always_comb begin
        n_terms.rv = w_dv_x * COEF_RV;
        n_terms.gv = w_dv_x * COEF_GV;
        n_terms.gu = w_du_x * COEF_GU;
        n_terms.bu = w_du_x * COEF_BU;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms       <= n_terms;
        r_luma_first  <= i_luma_first;
        r_luma_second <= i_luma_second;
        r_frame_end   <= i_frame_end;
    end

    assign o_valid       = r_valid;
    assign o_luma_first  = r_luma_first;
    assign o_luma_second = r_luma_second;
    assign o_frame_end   = r_frame_end;
    assign o_terms       = r_terms;

endmodule

>>> hdl/yuyv_pix_sum.sv
// Second stage: per-pixel channel sums of luma and chroma terms.
module yuyv_pix_sum (
    input  logic                       i_clk,
    input  logic [7:0]                 i_luma,
    input  yuyv_pkg::t_chroma_terms    i_terms,
    output yuyv_pkg::t_pix_sums        o_sums
);
    import yuyv_pkg::*;

    t_sum       w_base;
    t_pix_sums  n_sums;
    t_pix_sums  r_sums;

    assign w_base = $signed({2'b00, i_luma, {FRAC_BITS{1'b0}}});

    always_comb begin
        n_sums.r = w_base + t_sum'(i_terms.rv);
        n_sums.g = w_base - t_sum'(i_terms.gv) - t_sum'(i_terms.gu);
        n_sums.b = w_base + t_sum'(i_terms.bu);
    end

    always_ff @(posedge i_clk) begin
        r_sums <= n_sums;
    end

    assign o_sums = r_sums;

endmodule

>>> hdl/yuyv_clamp_scale.sv
// Third stage: clamp one channel sum to 0..255 and scale by 220/256.
module yuyv_clamp_scale (
    input  logic                   i_clk,
    input  yuyv_pkg::t_sum         i_sum,
    output logic [7:0]             o_pix
);
    import yuyv_pkg::*;

    logic [PIX_W-1:0]   w_chan;
    logic [SCALE_W-1:0] w_scaled;
    logic [PIX_W-1:0]   r_pix;

    always_comb begin
        if (i_sum[SUM_W-1]) begin
            w_chan = '0;
        end else if (|i_sum[SUM_W-2:FRAC_BITS+PIX_W]) begin
            w_chan = PIX_MAX;
        end else begin
            w_chan = i_sum[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
    end

    assign w_scaled = SCALE_W'(w_chan) * SCALE_W'(SCALE_MUL);

    always_ff @(posedge i_clk) begin
        r_pix <= w_scaled[SCALE_W-1:PIX_W];
    end

    assign o_pix = r_pix;

endmodule

>>> hdl/yuyv_to_rgb24_scaled_unit.sv
// Top level: YUYV 4:2:2 word to two scaled RGB24 pixels, three-stage pipeline.
// The valid strobe and frame-end flag travel with the data through the multiply, sum and clamp-scale stage registers.
// Throughput: one request per cycle; the multiply, sum and clamp-scale stages each
// hold one word, so o_busy stays low.
// Reset (synchronous, active low) clears the stage valid bits; data registers are not reset.
module yuyv_to_rgb24_scaled_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [7:0] i_luma_first,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_luma_second,
    input  logic [7:0] i_chroma_red,
    input  logic       i_frame_end,
    output logic       o_valid,
    output logic [7:0] o_red_first,
    output logic [7:0] o_green_first,
    output logic [7:0] o_blue_first,
    output logic [7:0] o_red_second,
    output logic [7:0] o_green_second,
    output logic [7:0] o_blue_second,
    output logic       o_last_of_frame
);
    import yuyv_pkg::*;

    logic           w_accept;
    logic           w_s1_valid;
    logic [7:0]     w_s1_luma_first;
    logic [7:0]     w_s1_luma_second;
    logic           w_s1_frame_end;
    t_chroma_terms  w_s1_terms;
    t_pix_sums      w_s2_first;
    t_pix_sums      w_s2_second;
    logic           r_s2_valid;
    logic           r_s2_frame_end;
    logic           r_s3_valid;
    logic           r_s3_frame_end;

    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    yuyv_chroma_mul u_mul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_luma_first  (i_luma_first),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_second (i_luma_second),
        .i_chroma_red  (i_chroma_red),
        .i_frame_end   (i_frame_end),
        .o_valid       (w_s1_valid),
        .o_luma_first  (w_s1_luma_first),
        .o_luma_second (w_s1_luma_second),
        .o_frame_end   (w_s1_frame_end),
        .o_terms       (w_s1_terms)
    );

    yuyv_pix_sum u_sum_first (
        .i_clk   (i_clk),
        .i_luma  (w_s1_luma_first),
        .i_terms (w_s1_terms),
        .o_sums  (w_s2_first)
    );

    yuyv_pix_sum u_sum_second (
        .i_clk   (i_clk),
        .i_luma  (w_s1_luma_second),
        .i_terms (w_s1_terms),
        .o_sums  (w_s2_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= w_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_frame_end <= w_s1_frame_end;
        r_s3_frame_end <= r_s2_frame_end;
    end

    yuyv_clamp_scale u_r0 (.i_clk(i_clk), .i_sum(w_s2_first.r),  .o_pix(o_red_first));
    yuyv_clamp_scale u_g0 (.i_clk(i_clk), .i_sum(w_s2_first.g),  .o_pix(o_green_first));
    yuyv_clamp_scale u_b0 (.i_clk(i_clk), .i_sum(w_s2_first.b),  .o_pix(o_blue_first));
    yuyv_clamp_scale u_r1 (.i_clk(i_clk), .i_sum(w_s2_second.r), .o_pix(o_red_second));
    yuyv_clamp_scale u_g1 (.i_clk(i_clk), .i_sum(w_s2_second.g), .o_pix(o_green_second));
    yuyv_clamp_scale u_b1 (.i_clk(i_clk), .i_sum(w_s2_second.b), .o_pix(o_blue_second));

    assign o_valid         = r_s3_valid;
    assign o_last_of_frame = r_s3_frame_end;

endmodule

>>> tb/sv/yuyv_to_rgb24_scaled_unit_tb.sv
// Self-checking testbench for the YUYV 4:2:2 to scaled RGB24 converter.
`timescale 1ns / 1ps

module yuyv_to_rgb24_scaled_unit_tb;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 12;
    localparam int          IDLE_LIMIT   = 200;
    localparam int          MAX_REPORTS  = 10;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          Q16          = 16;
    localparam int          RGB_CEIL     = 255;
    localparam int          OUT_CEIL     = 219;
    localparam longint      SCALE_NUM    = 220;
    localparam int          SCALE_SHIFT  = 8;
    localparam longint      CHROMA_MID   = 128;
    localparam longint      K_RED_V      = 89831;
    localparam longint      K_GREEN_V    = 45744;
    localparam longint      K_GREEN_U    = 22127;
    localparam longint      K_BLUE_U     = 113538;

    typedef struct {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end;
    } t_yuyv_word;

    typedef struct {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       last_of_frame;
    } t_rgb_pair;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [7:0] i_luma_first;
    logic [7:0] i_chroma_blue;
    logic [7:0] i_luma_second;
    logic [7:0] i_chroma_red;
    logic       i_frame_end;
    logic       o_valid;
    logic [7:0] o_red_first;
    logic [7:0] o_green_first;
    logic [7:0] o_blue_first;
    logic [7:0] o_red_second;
    logic [7:0] o_green_second;
    logic [7:0] o_blue_second;
    logic       o_last_of_frame;

    t_rgb_pair rgb_expected_q[$];
    int        n_words;
    int        n_results;
    int        n_errors;
    int        n_frames;
    int        n_floor;
    int        n_ceil;
    int        idle_cycles;
    int        seen_words;
    int        seen_results;

    yuyv_to_rgb24_scaled_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_luma_first   (i_luma_first),
        .i_chroma_blue  (i_chroma_blue),
        .i_luma_second  (i_luma_second),
        .i_chroma_red   (i_chroma_red),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second),
        .o_last_of_frame(o_last_of_frame)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    function automatic logic [7:0] clamp_scale_channel(input longint acc);
        longint ch;
        if (acc < 0) begin
            ch = 0;
        end else begin
            ch = acc >>> Q16;
            if (ch > RGB_CEIL) begin
                ch = RGB_CEIL;
            end
        end
        return 8'((ch * SCALE_NUM) >>> SCALE_SHIFT);
    endfunction

    function automatic t_rgb_pair predict_rgb(input t_yuyv_word w);
        t_rgb_pair p;
        longint    du;
        longint    dv;
        longint    y0;
        longint    y1;
        du = longint'(w.chroma_blue) - CHROMA_MID;
        dv = longint'(w.chroma_red) - CHROMA_MID;
        y0 = longint'(w.luma_first) <<< Q16;
        y1 = longint'(w.luma_second) <<< Q16;
        p.red_first     = clamp_scale_channel(y0 + K_RED_V * dv);
        p.green_first   = clamp_scale_channel(y0 - K_GREEN_V * dv - K_GREEN_U * du);
        p.blue_first    = clamp_scale_channel(y0 + K_BLUE_U * du);
        p.red_second    = clamp_scale_channel(y1 + K_RED_V * dv);
        p.green_second  = clamp_scale_channel(y1 - K_GREEN_V * dv - K_GREEN_U * du);
        p.blue_second   = clamp_scale_channel(y1 + K_BLUE_U * du);
        p.last_of_frame = w.frame_end;
        return p;
    endfunction

    function automatic t_yuyv_word make_word(input int y0, input int u, input int y1,
                                             input int v, input bit fe);
        t_yuyv_word w;
        w.luma_first  = 8'(y0);
        w.chroma_blue = 8'(u);
        w.luma_second = 8'(y1);
        w.chroma_red  = 8'(v);
        w.frame_end   = fe;
        return w;
    endfunction

    function automatic t_yuyv_word random_word();
        return make_word($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         1'($urandom_range(0, 1)));
    endfunction

    function automatic int edge_byte();
        if ($urandom_range(0, 1) == 0) begin
            return $urandom_range(0, 15);
        end
        return $urandom_range(240, 255);
    endfunction

    function automatic int count_rails(input logic [7:0] ch, input int rail);
        return (ch == rail) ? 1 : 0;
    endfunction

    task automatic note_rails(input t_rgb_pair p);
        n_floor += count_rails(p.red_first, 0) + count_rails(p.green_first, 0)
                 + count_rails(p.blue_first, 0) + count_rails(p.red_second, 0)
                 + count_rails(p.green_second, 0) + count_rails(p.blue_second, 0);
        n_ceil  += count_rails(p.red_first, OUT_CEIL) + count_rails(p.green_first, OUT_CEIL)
                 + count_rails(p.blue_first, OUT_CEIL) + count_rails(p.red_second, OUT_CEIL)
                 + count_rails(p.green_second, OUT_CEIL)
                 + count_rails(p.blue_second, OUT_CEIL);
    endtask

    // gap = number of idle cycles before the request goes out
    task automatic send_word(input t_yuyv_word w, input int gap);
        t_rgb_pair p;
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_luma_first  <= w.luma_first;
        i_chroma_blue <= w.chroma_blue;
        i_luma_second <= w.luma_second;
        i_chroma_red  <= w.chroma_red;
        i_frame_end   <= w.frame_end;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        p = predict_rgb(w);
        rgb_expected_q.push_back(p);
        note_rails(p);
        n_words++;
        if (w.frame_end) begin
            n_frames++;
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("mismatch result %0d %s: expected %0d, got %0d",
                         n_results, name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_pair p;
        if (i_rst_n && o_valid === 1'b1) begin
            if (rgb_expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("unexpected result with no request pending");
                end
            end else begin
                p = rgb_expected_q.pop_front();
                check_field("red_first", p.red_first, o_red_first);
                check_field("green_first", p.green_first, o_green_first);
                check_field("blue_first", p.blue_first, o_blue_first);
                check_field("red_second", p.red_second, o_red_second);
                check_field("green_second", p.green_second, o_green_second);
                check_field("blue_second", p.blue_second, o_blue_second);
                check_field("last_of_frame", p.last_of_frame, o_last_of_frame);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || n_words != seen_words || n_results != seen_results) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        seen_words   = n_words;
        seen_results = n_results;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_directed_corners();
        send_word(make_word(0, 0, 0, 0, 1'b0), 0);
        send_word(make_word(255, 255, 255, 255, 1'b1), 0);
        send_word(make_word(0, 128, 255, 128, 1'b0), 0);
        send_word(make_word(128, 128, 128, 128, 1'b1), 2);
        send_word(make_word(0, 128, 0, 0, 1'b0), 0);
        send_word(make_word(255, 128, 255, 255, 1'b0), 0);
        send_word(make_word(0, 255, 0, 255, 1'b0), 1);
        send_word(make_word(255, 0, 255, 0, 1'b1), 0);
        send_word(make_word(0, 255, 0, 128, 1'b0), 0);
        send_word(make_word(255, 0, 128, 128, 1'b0), 3);
        send_word(make_word(16, 128, 235, 128, 1'b0), 0);
        send_word(make_word(235, 240, 16, 16, 1'b1), 0);
        send_word(make_word(1, 127, 254, 129, 1'b0), 8);
        send_word(make_word(170, 85, 85, 170, 1'b0), 0);
        send_word(make_word(85, 170, 170, 85, 1'b1), 0);
        send_word(make_word(100, 0, 200, 255, 1'b0), 0);
        send_word(make_word(200, 255, 100, 0, 1'b0), 5);
        send_word(make_word(255, 128, 0, 128, 1'b1), 0);
        send_word(make_word(64, 192, 192, 64, 1'b0), 0);
        send_word(make_word(254, 1, 1, 254, 1'b1), 0);
        go_idle();
    endtask

    task automatic test_random_frames(input int n);
        int         left;
        int         frame_len;
        int         k;
        bit         quiet;
        t_yuyv_word w;
        left = n;
        while (left > 0) begin
            frame_len = $urandom_range(1, 48);
            if (frame_len > left) begin
                frame_len = left;
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < frame_len; k++) begin
                w = random_word();
                w.frame_end = (k == frame_len - 1);
                send_word(w, quiet ? 0 : $urandom_range(0, 8));
            end
            left -= frame_len;
        end
        go_idle();
    endtask

    task automatic test_clamp_edges(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_word(make_word(edge_byte(), edge_byte(), edge_byte(), edge_byte(),
                                1'($urandom_range(0, 1))), $urandom_range(0, 8));
        end
        go_idle();
    endtask

    initial begin
        n_words       = 0;
        n_results     = 0;
        n_errors      = 0;
        n_frames      = 0;
        n_floor       = 0;
        n_ceil        = 0;
        idle_cycles   = 0;
        seen_words    = 0;
        seen_results  = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_luma_first  = 8'd0;
        i_chroma_blue = 8'd0;
        i_luma_second = 8'd0;
        i_chroma_red  = 8'd0;
        i_frame_end   = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_frames(1300);
        test_clamp_edges(200);

        while (rgb_expected_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words in %0d frames, %0d results checked, %0d errors",
                 n_words, n_frames, n_results, n_errors);
        $display("channels clamped to floor: %0d, to ceiling: %0d", n_floor, n_ceil);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
